FILE: hdl/cdwt_pkg.sv
// Shared types and constants for the clock drift window trim block.
package cdwt_pkg;

  localparam int WindowDepth = 64;
  localparam int PtrBits     = 6;
  localparam int CountBits   = 7;
  localparam int SampleBits  = 32;
  localparam int TimeBits    = 32;
  localparam int SumBits     = 40;
  localparam int SqBits      = 70;
  localparam int VarBits     = 80;
  localparam int RootBits    = 40;
  localparam int QuoBits     = 42;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_EVAL  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] REG_WLEN   = 3'd0;
  localparam logic [2:0] REG_MINCNT = 3'd1;
  localparam logic [2:0] REG_HOLD   = 3'd2;
  localparam logic [2:0] REG_SPREAD = 3'd3;
  localparam logic [2:0] REG_PPS    = 3'd4;
  localparam logic [2:0] REG_MAXST  = 3'd5;

  typedef struct packed {
    logic start;
    logic accum;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic var_load;
    logic root_step;
    logic div_load;
    logic div_step;
    logic finish;
  } cdwt_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic root_done;
    logic div_done;
  } cdwt_status_t;

endpackage

FILE: hdl/cdwt_ctrl.sv
// Sequencer for one request: walk, square sums, root, divisions.
module cdwt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic                  out_free,
  input  cdwt_pkg::cdwt_status_t status,
  output cdwt_pkg::cdwt_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_WALK  = 10'b0000000010,
    S_MA    = 10'b0000000100,
    S_MB    = 10'b0000001000,
    S_MC    = 10'b0000010000,
    S_VAR   = 10'b0000100000,
    S_ROOT  = 10'b0001000000,
    S_DLOAD = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.accum = 1'b1;
        if (status.walk_done) state_next = S_MA;
      end
      S_MA: begin
        cmd.mul_a = 1'b1;
        state_next = S_MB;
      end
      S_MB: begin
        cmd.mul_b = 1'b1;
        state_next = S_MC;
      end
      S_MC: begin
        cmd.mul_c = 1'b1;
        state_next = S_VAR;
      end
      S_VAR: begin
        cmd.var_load = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hdl/cdwt_datapath.sv
// Sample ring, accumulators, root and divider units, gates and result.
module cdwt_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cdwt_pkg::cdwt_cmd_t         cmd,
  output cdwt_pkg::cdwt_status_t      status,
  input  logic [1:0]                  in_cmd,
  input  logic [cdwt_pkg::SampleBits-1:0] in_sample,
  input  logic [cdwt_pkg::TimeBits-1:0]   in_time,
  input  logic [6:0]                  cfg_wlen,
  input  logic [6:0]                  cfg_mincnt,
  input  logic [31:0]                 cfg_hold,
  input  logic [30:0]                 cfg_spread,
  input  logic [30:0]                 cfg_pps,
  input  logic [14:0]                 cfg_maxst,
  output logic                        res_ok,
  output logic signed [15:0]          res_trim,
  output logic signed [31:0]          res_mean,
  output logic [30:0]                 res_spread,
  output logic [6:0]                  res_count
);

  localparam int PB = cdwt_pkg::PtrBits;
  localparam int CB = cdwt_pkg::CountBits;

  logic [cdwt_pkg::SampleBits-1:0] ring [cdwt_pkg::WindowDepth];
  logic [cdwt_pkg::SampleBits-1:0] rd_data;
  logic [PB-1:0] head;
  logic [CB-1:0] held;
  logic [cdwt_pkg::TimeBits-1:0] last_time;
  logic [1:0] op;
  logic [cdwt_pkg::TimeBits-1:0] now;

  logic [CB-1:0] issue_cnt, acc_cnt;
  logic          rd_valid;
  logic signed [cdwt_pkg::SumBits-1:0] sum;
  logic [cdwt_pkg::SqBits-1:0] sumsq;
  logic [63:0] sq;
  logic        sq_valid;

  logic [cdwt_pkg::SumBits-1:0] as;
  logic        neg;
  logic [cdwt_pkg::VarBits-1:0] nsq, assq, vreg, rres, rone;
  logic [cdwt_pkg::RootBits-1:0] root;
  logic [5:0]  rbit;
  logic        root_done;

  logic [1:0]  dsel;
  logic [5:0]  dcnt;
  logic [cdwt_pkg::QuoBits-1:0] dnum, dquo;
  logic [cdwt_pkg::QuoBits:0]   drem;
  logic [cdwt_pkg::QuoBits-1:0] dden;
  logic [cdwt_pkg::QuoBits-1:0] q_mean, q_spread, q_trim;
  logic        div_done;

  logic [CB-1:0] len;
  logic [PB-1:0] rd_addr;
  logic [31:0]   mag_in;
  logic [cdwt_pkg::VarBits-1:0] rtry;
  logic [cdwt_pkg::QuoBits:0] rem_sh;
  logic [37:0]   pps_n;
  logic [cdwt_pkg::QuoBits-1:0] trim_mag;
  logic          timed;

  assign len = (cfg_wlen == '0) ? CB'(1) :
               (cfg_wlen > CB'(cdwt_pkg::WindowDepth)) ? CB'(cdwt_pkg::WindowDepth) : cfg_wlen;
  assign rd_addr = head - held[PB-1:0] + issue_cnt[PB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      held      <= '0;
      last_time <= '0;
    end else if (cmd.start) begin
      if (in_cmd == cdwt_pkg::CMD_ADD) begin
        head <= head + PB'(1);
        if (held < len) held <= held + CB'(1);
      end else if (in_cmd == cdwt_pkg::CMD_MARK) begin
        last_time <= in_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && in_cmd == cdwt_pkg::CMD_ADD) ring[head] <= in_sample;
    rd_data <= ring[rd_addr];
  end

  assign mag_in = rd_data[31] ? (32'd0 - rd_data) : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op        <= in_cmd;
      now       <= in_time;
      issue_cnt <= '0;
      acc_cnt   <= '0;
      rd_valid  <= 1'b0;
      sq_valid  <= 1'b0;
      sum       <= '0;
      sumsq     <= '0;
    end else if (cmd.accum) begin
      rd_valid <= (issue_cnt < held);
      if (issue_cnt < held) issue_cnt <= issue_cnt + CB'(1);
      if (rd_valid) begin
        sum <= sum + cdwt_pkg::SumBits'(signed'(rd_data));
        sq  <= mag_in * mag_in;
      end
      sq_valid <= rd_valid;
      if (sq_valid) begin
        sumsq   <= sumsq + cdwt_pkg::SqBits'(sq);
        acc_cnt <= acc_cnt + CB'(1);
      end
    end
  end

  assign status.walk_done = cmd.accum && (acc_cnt == held) && !rd_valid && !sq_valid
                            && (issue_cnt == held);

  assign rtry = rres + rone;

  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      neg <= sum[cdwt_pkg::SumBits-1];
      as  <= sum[cdwt_pkg::SumBits-1] ? (cdwt_pkg::SumBits'(0) - sum) : sum;
      nsq <= cdwt_pkg::VarBits'(sumsq[34:0] * held);
    end
    if (cmd.mul_b) begin
      nsq  <= nsq + (cdwt_pkg::VarBits'(sumsq[cdwt_pkg::SqBits-1:35] * held) << 35);
      assq <= cdwt_pkg::VarBits'(as[19:0] * as[19:0]);
    end
    if (cmd.mul_c) begin
      assq <= assq + (cdwt_pkg::VarBits'(as[39:20] * as[19:0]) << 21)
                   + (cdwt_pkg::VarBits'(as[39:20] * as[39:20]) << 40);
    end
    if (cmd.var_load) begin
      vreg <= nsq - assq;
      rres <= '0;
      rone <= cdwt_pkg::VarBits'(1) << (2 * cdwt_pkg::RootBits - 2);
      rbit <= 6'(cdwt_pkg::RootBits - 1);
      root_done <= 1'b0;
    end
    if (cmd.root_step && !root_done) begin
      if (vreg >= rtry) begin
        vreg <= vreg - rtry;
        rres <= (rres >> 1) + rone;
      end else begin
        rres <= rres >> 1;
      end
      rone <= rone >> 2;
      if (rbit == '0) root_done <= 1'b1;
      else            rbit <= rbit - 6'd1;
    end
  end

  assign root = rres[cdwt_pkg::RootBits-1:0];
  assign status.root_done = root_done;

  assign pps_n = 38'((cfg_pps == '0) ? 31'd1 : cfg_pps) * 38'(held);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dsel <= 2'd0;
      dcnt <= 6'(cdwt_pkg::QuoBits);
      dnum <= {as, 1'b0} + cdwt_pkg::QuoBits'(held);
      dden <= cdwt_pkg::QuoBits'({held, 1'b0});
      drem <= '0;
      dquo <= '0;
      div_done <= 1'b0;
    end else if (cmd.div_step && !div_done) begin
      if (dcnt != '0) begin
        drem <= (rem_sh >= {1'b0, dden}) ? rem_sh - {1'b0, dden} : rem_sh;
        dquo <= {dquo[cdwt_pkg::QuoBits-2:0], rem_sh >= {1'b0, dden}};
        dnum <= {dnum[cdwt_pkg::QuoBits-2:0], 1'b0};
        dcnt <= dcnt - 6'd1;
      end else begin
        dcnt <= 6'(cdwt_pkg::QuoBits);
        drem <= '0;
        dquo <= '0;
        dsel <= dsel + 2'd1;
        case (dsel)
          2'd0: begin
            q_mean <= dquo;
            dnum   <= cdwt_pkg::QuoBits'(root);
            dden   <= cdwt_pkg::QuoBits'(held);
          end
          2'd1: begin
            q_spread <= dquo;
            dnum     <= {as, 1'b0} + cdwt_pkg::QuoBits'(pps_n);
            dden     <= cdwt_pkg::QuoBits'({pps_n, 1'b0});
          end
          default: begin
            q_trim   <= dquo;
            div_done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rem_sh = {drem[cdwt_pkg::QuoBits-1:0], dnum[cdwt_pkg::QuoBits-1]};
  assign status.div_done = div_done;

  assign trim_mag = (q_trim > cdwt_pkg::QuoBits'(cfg_maxst)) ? cdwt_pkg::QuoBits'(cfg_maxst)
                                                             : q_trim;
  assign timed = (last_time != '0) ? ((now - last_time) >= cfg_hold) : (now >= cfg_hold);

  always_ff @(posedge clk) begin
    if (div_done && cmd.div_step) begin
      res_count <= held;
      if (held == '0) begin
        res_mean   <= '0;
        res_spread <= '0;
        res_trim   <= '0;
      end else begin
        res_mean   <= neg ? 32'(32'd0 - q_mean[31:0]) : q_mean[31:0];
        res_spread <= (held >= CB'(2)) ? q_spread[30:0] : 31'd0;
        if (op == cdwt_pkg::CMD_EVAL)
          res_trim <= neg ? 16'(16'd0 - trim_mag[15:0]) : trim_mag[15:0];
        else
          res_trim <= '0;
      end
      res_ok <= (op == cdwt_pkg::CMD_EVAL) && (held >= cfg_mincnt) && timed &&
                (((held >= CB'(2)) ? q_spread[30:0] : 31'd0) < cfg_spread);
    end
  end

endmodule

FILE: hdl/clock_drift_window_trim_core.sv
// Top level of the clock drift window trim block.
// Each request (add sample, evaluate, record adjustment) yields one result. The result is
// computed by a walk over the held samples through one registered ring read port and one
// squarer, then wide products, a 40-step square root, then three 42-step restoring
// divisions (mean, spread, trim) on one shared divider. One request is handled at a time;
// input is taken again the cycle after the result enters the output register, which
// waits only while an earlier result is still untaken.
module clock_drift_window_trim_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // drift_sample[31:0], time_sec[63:32]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // trim_steps[15:0], mean_drift[47:16],
                                     // drift_spread[78:48], sample_count[85:79]
  output logic        m_axis_tuser,  // adjust_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [6:0]  wlen, mincnt;
  logic [31:0] hold;
  logic [30:0] spread_lim, pps;
  logic [14:0] maxst;
  cdwt_pkg::cdwt_cmd_t    cmd;
  cdwt_pkg::cdwt_status_t status;
  logic busy, in_fire, out_free;
  logic res_ok;
  logic signed [15:0] res_trim;
  logic signed [31:0] res_mean;
  logic [30:0] res_spread;
  logic [6:0]  res_count;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= 7'd32; mincnt <= 7'd10; hold <= 32'd60;
      spread_lim <= 31'd32768; pps <= 31'd6554; maxst <= 15'd127;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdwt_pkg::REG_WLEN:   wlen <= cfg_data[6:0];
        cdwt_pkg::REG_MINCNT: mincnt <= cfg_data[6:0];
        cdwt_pkg::REG_HOLD:   hold <= cfg_data;
        cdwt_pkg::REG_SPREAD: spread_lim <= cfg_data[30:0];
        cdwt_pkg::REG_PPS:    pps <= cfg_data[30:0];
        cdwt_pkg::REG_MAXST:  maxst <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy && !rst;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.finish) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tuser <= res_ok;
      m_axis_tdata <= {2'b00, res_count, res_spread, res_mean, res_trim};
    end
  end

  cdwt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy)
  );

  cdwt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_cmd(s_axis_tuser), .in_sample(s_axis_tdata[31:0]), .in_time(s_axis_tdata[63:32]),
    .cfg_wlen(wlen), .cfg_mincnt(mincnt), .cfg_hold(hold), .cfg_spread(spread_lim),
    .cfg_pps(pps), .cfg_maxst(maxst),
    .res_ok(res_ok), .res_trim(res_trim), .res_mean(res_mean),
    .res_spread(res_spread), .res_count(res_count)
  );

endmodule

FILE: hdl/cdwt_checker.sv
// Port-level checks for the clock drift window trim block, with bind.
module cdwt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken during work");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[85:79] <= 7'd64)
    else $error("sample count beyond window depth");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[85:79] == 7'd0) |-> m_axis_tdata[78:0] == '0)
    else $error("empty window with non-zero statistics");

  a_spread: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[85:79] < 7'd2) |-> m_axis_tdata[78:48] == '0)
    else $error("spread reported with fewer than two samples");

endmodule

bind clock_drift_window_trim_core cdwt_checker u_cdwt_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

FILE: sim/clock_drift_window_trim_checker.sv
// Checker for the clock drift window trim block: predicts each result and compares it.
module clock_drift_window_trim_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic        adjust_ok;
    logic [15:0] trim_steps;
    logic [31:0] mean_drift;
    logic [30:0] drift_spread;
    logic [6:0]  sample_count;
  } trim_result_t;

  trim_result_t result_q[$];

  logic [31:0] ring [cdwt_pkg::WindowDepth];
  int unsigned head, held;
  logic [31:0] last_mark;
  logic [6:0]  wlen, mincnt;
  logic [31:0] holdoff;
  logic [30:0] spread_lim, pps;
  logic [14:0] max_step;

  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  function automatic trim_result_t predict_trim(logic [1:0] cmd, logic [31:0] drift,
                                               logic [31:0] now);
    trim_result_t res;
    int unsigned  len, idx;
    longint       sum;
    logic [127:0] sumsq, var_w, as_w, n_w, d_w;
    logic [63:0]  as, mean_mag, spread, trim_mag, d;
    logic         neg, timed;
    if (cmd == cdwt_pkg::CMD_ADD) begin
      len = wlen;
      if (len < 1) len = 1;
      if (len > cdwt_pkg::WindowDepth) len = cdwt_pkg::WindowDepth;
      ring[head] = drift;
      head = (head + 1) % cdwt_pkg::WindowDepth;
      if (held < len) held++;
    end else if (cmd == cdwt_pkg::CMD_MARK) begin
      last_mark = now;
    end
    sum = 0;
    sumsq = '0;
    for (int i = 0; i < held; i++) begin
      idx = (head + cdwt_pkg::WindowDepth - held + i) % cdwt_pkg::WindowDepth;
      sum += longint'(signed'(ring[idx]));
      sumsq += 128'(longint'(signed'(ring[idx])) * longint'(signed'(ring[idx])));
    end
    neg = sum < 0;
    as = neg ? 64'(-sum) : 64'(sum);
    mean_mag = 0;
    spread = 0;
    trim_mag = 0;
    if (held > 0) begin
      as_w = {64'd0, as};
      n_w = 128'(held);
      mean_mag = 64'((2 * as_w + n_w) / (2 * n_w));
      if (held >= 2) begin
        var_w = sumsq * n_w - as_w * as_w;
        spread = root_floor(var_w) / 64'(held);
      end
      if (cmd == cdwt_pkg::CMD_EVAL) begin
        d = 64'(held) * 64'((pps == 0) ? 31'd1 : pps);
        d_w = {64'd0, d};
        trim_mag = 64'((2 * as_w + d_w) / (2 * d_w));
        if (trim_mag > 64'(max_step)) trim_mag = 64'(max_step);
      end
    end
    res.adjust_ok = 1'b0;
    if (cmd == cdwt_pkg::CMD_EVAL && held >= mincnt) begin
      timed = (last_mark != 0) ? ((now - last_mark) >= holdoff) : (now >= holdoff);
      res.adjust_ok = timed && (spread < 64'(spread_lim));
    end
    res.trim_steps   = 16'(neg ? -trim_mag : trim_mag);
    res.mean_drift   = 32'(neg ? -mean_mag : mean_mag);
    res.drift_spread = 31'(spread);
    res.sample_count = 7'(held);
    return res;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    trim_result_t want, got;
    if (rst) begin
      head = 0;
      held = 0;
      last_mark = '0;
      wlen = 7'd32;
      mincnt = 7'd10;
      holdoff = 32'd60;
      spread_lim = 31'd32768;
      pps = 31'd6554;
      max_step = 15'd127;
      mismatches <= 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cdwt_pkg::REG_WLEN:   wlen = cfg_data[6:0];
          cdwt_pkg::REG_MINCNT: mincnt = cfg_data[6:0];
          cdwt_pkg::REG_HOLD:   holdoff = cfg_data;
          cdwt_pkg::REG_SPREAD: spread_lim = cfg_data[30:0];
          cdwt_pkg::REG_PPS:    pps = cfg_data[30:0];
          cdwt_pkg::REG_MAXST:  max_step = cfg_data[14:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.adjust_ok    = m_axis_tuser;
        got.trim_steps   = m_axis_tdata[15:0];
        got.mean_drift   = m_axis_tdata[47:16];
        got.drift_spread = m_axis_tdata[78:48];
        got.sample_count = m_axis_tdata[85:79];
        if (result_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"mismatch: expected ok=%0d trim=%0d mean=%0d spread=%0d cnt=%0d,",
                        " got ok=%0d trim=%0d mean=%0d spread=%0d cnt=%0d"},
                       want.adjust_ok, $signed(want.trim_steps), $signed(want.mean_drift),
                       want.drift_spread, want.sample_count, got.adjust_ok,
                       $signed(got.trim_steps), $signed(got.mean_drift), got.drift_spread,
                       got.sample_count);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_q = {result_q, predict_trim(s_axis_tuser, s_axis_tdata[31:0],
                                           s_axis_tdata[63:32])};
    end
  end

endmodule

FILE: sim/tb_clock_drift_window_trim_core.sv
// Testbench top for the clock drift window trim block: stimulus and verdict.
module tb_clock_drift_window_trim_core;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = cdwt_pkg::CMD_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = cdwt_pkg::REG_WLEN;
  logic [31:0] cfg_data = '0;
  int          mismatches, pending;
  int          stall_free = 0;
  int          quiet = 0;
  logic [31:0] holdoff_now = 32'd60;
  logic [31:0] mark_time = 32'd0;

  always #4 clk = ~clk;

  clock_drift_window_trim_core u_top (.*);

  clock_drift_window_trim_checker u_chk (.*);

  always @(posedge clk) begin
    m_axis_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 9);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("tb_clock_drift_window_trim_core: done, errors");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [31:0] drift, logic [31:0] now);
    while (!stall_free && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {now, drift};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    if (idx == cdwt_pkg::REG_HOLD) holdoff_now = val;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_all(logic [6:0] wl, logic [6:0] mc, logic [31:0] ho, logic [30:0] sl,
                         logic [30:0] pp, logic [14:0] ms);
    drain();
    write_reg(cdwt_pkg::REG_WLEN, 32'(wl));
    write_reg(cdwt_pkg::REG_MINCNT, 32'(mc));
    write_reg(cdwt_pkg::REG_HOLD, ho);
    write_reg(cdwt_pkg::REG_SPREAD, 32'(sl));
    write_reg(cdwt_pkg::REG_PPS, 32'(pp));
    write_reg(cdwt_pkg::REG_MAXST, 32'(ms));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0: pick_time = $urandom();
      1: pick_time = mark_time + holdoff_now + $urandom_range(2) - 1;
      2: pick_time = holdoff_now + $urandom_range(2) - 1;
      default: pick_time = mark_time + $urandom_range(200);
    endcase
  endfunction

  task automatic random_phase(int count, logic [31:0] centre, int spread_bits);
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          send_request(cdwt_pkg::CMD_ADD, (spread_bits >= 32) ? $urandom()
                       : centre + ($urandom() >> (32 - spread_bits)), $urandom());
        9, 10, 11, 12: send_request(cdwt_pkg::CMD_EVAL, $urandom(), pick_time());
        13, 14: begin
          t = pick_time();
          if ($urandom_range(9) == 0) t = 32'd0;
          mark_time = t;
          send_request(cdwt_pkg::CMD_MARK, $urandom(), t);
        end
        default: send_request(cdwt_pkg::CMD_SPARE, $urandom(), $urandom());
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes at reset settings
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd0);
    send_request(cdwt_pkg::CMD_ADD, 32'h7fffffff, 32'hffffffff);
    send_request(cdwt_pkg::CMD_EVAL, 32'hffffffff, 32'd59);
    send_request(cdwt_pkg::CMD_ADD, 32'h80000000, 32'h0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd60);
    send_request(cdwt_pkg::CMD_MARK, 32'h0, 32'd0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'hffffffff);
    send_request(cdwt_pkg::CMD_SPARE, 32'hffffffff, 32'hffffffff);
    send_request(cdwt_pkg::CMD_MARK, 32'h0, 32'hfffffff0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd44);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd43);
    set_all(7'd0, 7'd0, 32'd0, 31'h7fffffff, 31'd0, 15'h7fff);
    send_request(cdwt_pkg::CMD_ADD, 32'h80000000, 32'd0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd0);
    send_request(cdwt_pkg::CMD_ADD, 32'h7fffffff, 32'd0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd5);
    set_all(7'd127, 7'd64, 32'hffffffff, 31'd0, 31'h7fffffff, 15'd0);
    for (int i = 0; i < 6; i++) send_request(cdwt_pkg::CMD_ADD, 32'h80000000, 32'd0);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'hffffffff);
    set_all(7'd3, 7'd2, 32'd10, 31'd1000, 31'd1, 15'd100);
    send_request(cdwt_pkg::CMD_EVAL, 32'h0, 32'd10);
    // random phases across settings
    random_phase(200, 32'h00010000, 12);
    set_all(7'd64, 7'd20, 32'd5, 31'h00020000, 31'd6554, 15'd127);
    stall_free = 1;
    random_phase(150, 32'hfff00000, 16);
    stall_free = 0;
    set_all(7'd8, 7'd1, 32'd0, 31'h7fffffff, 31'd3, 15'h7fff);
    random_phase(200, 32'h0, 32);
    set_all(7'd1, 7'd0, 32'd100, 31'd0, 31'h7fffffff, 15'd1);
    random_phase(150, 32'h00001000, 8);
    set_all(7'd20, 7'd10, 32'd60, 31'h00008000, 31'd0, 15'd50);
    random_phase(300, 32'hffff8000, 16);
    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_clock_drift_window_trim_core: done, clean");
    end else begin
      $display("tb_clock_drift_window_trim_core: done, errors");
    end
    $finish;
  end

endmodule
